FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the text console.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: rtl/tcw_pkg.sv
// Package of the text console: payload structs, command codes, character constants
// and the memory request struct. No dependencies.
package tcw_pkg;

	localparam int DEF_COLS = 80;
	localparam int DEF_ROWS = 25;

	localparam int CELL_W = 16;
	localparam int CUR_W  = 11;
	// Address width of the memory request; covers the largest screen (32 x 128).
	localparam int MEM_AW = 12;

	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_SPACE     = 8'd32;
	localparam logic [7:0] DEF_ATTR_RST = 8'd15;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_BKSP  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] char_code;
		logic [7:0] attribute;
		logic       use_cursor;
		logic [6:0] column;
		logic [4:0] row_index;
	} tcw_in_t;

	typedef struct packed {
		logic [CUR_W-1:0] cursor_pos;
		logic [7:0]       read_char;
		logic [7:0]       read_attr;
		logic             scrolled;
		logic             status;
	} tcw_out_t;

	typedef struct packed {
		logic              we;
		logic [MEM_AW-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [MEM_AW-1:0] raddr;
	} mem_req_t;

endpackage

FILE: rtl/tcw_cell_mem.sv
// Cell store of the text console: one write port and one registered read port.
// Depends on tcw_pkg for the request struct and cell width.
module tcw_cell_mem #(
	parameter int DEPTH = tcw_pkg::DEF_COLS * tcw_pkg::DEF_ROWS
) (
	input  logic                          clk,
	input  tcw_pkg::mem_req_t             req,
	output logic [tcw_pkg::CELL_W-1:0]    rd_data
);
	import tcw_pkg::*;

	localparam int ADDR_W = $clog2(DEPTH);

	logic [CELL_W-1:0] mem [DEPTH];
	logic [CELL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[ADDR_W-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= mem[req.raddr[ADDR_W-1:0]];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/tcw_ctrl.sv
// Command sequencer of the text console: cursor, memory walks and the result register.
// Depends on tcw_pkg; drives the request port of tcw_cell_mem.
module tcw_ctrl #(
	parameter int COLS = tcw_pkg::DEF_COLS,
	parameter int ROWS = tcw_pkg::DEF_ROWS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  tcw_pkg::tcw_in_t           cmd_data,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output tcw_pkg::tcw_out_t          rsp_data,
	input  logic [7:0]                 default_attr,
	output tcw_pkg::mem_req_t          mem_req,
	input  logic [tcw_pkg::CELL_W-1:0] mem_rd_data
);
	import tcw_pkg::*;

	localparam int CELLS  = ROWS * COLS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int LW     = ADDR_W + 1;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int RW1    = ROW_W + 1;
	localparam int COL_W  = $clog2(COLS);
	localparam int COL_CW = 8;
	localparam int ROW_CW = 6;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_RESP,
		ST_MOVE,
		ST_FILL
	} state_t;

	state_t            state_q;
	tcw_in_t           item_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ADDR_W-1:0] cur_lin_q;
	logic [ADDR_W-1:0] scan_q;
	logic [CELL_W-1:0] fill_cell_q;
	logic              rd_cell_q;
	tcw_out_t          res_q;
	tcw_out_t          out_q;
	logic              out_valid_q;

	logic              slot_free;
	logic              out_load;
	logic              exp_ok, needs_pos, bad, is_nl, scroll, bs_ok, ex_direct;
	logic [ROW_W-1:0]  trow, nrow, brow;
	logic [COL_W-1:0]  tcol, ncol, bcol;
	logic [ADDR_W-1:0] tlin, nlin, blin;
	logic [RW1-1:0]    nrow_w;
	logic [LW-1:0]     nlin_w;
	logic [7:0]        put_attr;
	tcw_out_t          ex_res;
	tcw_out_t          resp_res;

	assign slot_free = !out_valid_q || rsp_ready;
	// The result register takes a new result straight from the execute cycle or from
	// the response state, whenever the previous one has gone or is leaving.
	assign out_load  = slot_free &&
		(((state_q == ST_EXEC) && ex_direct) || (state_q == ST_RESP));
	assign cmd_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	// Decode of the held item: target cell, next cursor, scroll and backspace step.
	always_comb begin
		exp_ok    = ({1'b0, item_q.column} < COL_CW'(COLS)) &&
			({1'b0, item_q.row_index} < ROW_CW'(ROWS));
		needs_pos = (item_q.cmd == CMD_PUT) || (item_q.cmd == CMD_READ);
		bad       = needs_pos && !item_q.use_cursor && !exp_ok;
		is_nl     = (item_q.char_code == CH_NEWLINE);
		put_attr  = (item_q.attribute == 8'd0) ? default_attr : item_q.attribute;

		if (item_q.use_cursor) begin
			trow = cur_row_q;
			tcol = cur_col_q;
			tlin = cur_lin_q;
		end else begin
			trow = item_q.row_index[ROW_W-1:0];
			tcol = item_q.column[COL_W-1:0];
			tlin = ADDR_W'(trow) * ADDR_W'(COLS) + ADDR_W'(tcol);
		end

		if (is_nl) begin
			ncol   = '0;
			nrow_w = RW1'(trow) + RW1'(1);
			nlin_w = LW'(tlin) - LW'(tcol) + LW'(COLS);
		end else if (tcol == COL_W'(COLS - 1)) begin
			ncol   = '0;
			nrow_w = RW1'(trow) + RW1'(1);
			nlin_w = LW'(tlin) + LW'(1);
		end else begin
			ncol   = tcol + COL_W'(1);
			nrow_w = RW1'(trow);
			nlin_w = LW'(tlin) + LW'(1);
		end

		scroll = (nrow_w == RW1'(ROWS));
		if (scroll) begin
			nrow = ROW_W'(ROWS - 1);
			nlin = ADDR_W'(nlin_w - LW'(COLS));
		end else begin
			nrow = nrow_w[ROW_W-1:0];
			nlin = nlin_w[ADDR_W-1:0];
		end

		bs_ok = (cur_lin_q != '0);
		blin  = cur_lin_q - ADDR_W'(1);
		if (cur_col_q == '0) begin
			brow = cur_row_q - ROW_W'(1);
			bcol = COL_W'(COLS - 1);
		end else begin
			brow = cur_row_q;
			bcol = cur_col_q - COL_W'(1);
		end

		ex_res            = '0;
		ex_res.cursor_pos = CUR_W'(cur_lin_q);
		ex_direct         = 1'b1;
		unique case (item_q.cmd)
			CMD_PUT: begin
				if (bad) begin
					ex_res.status = 1'b1;
				end else begin
					ex_res.cursor_pos = CUR_W'(nlin);
					ex_res.scrolled   = scroll;
					ex_direct         = !scroll;
				end
			end
			CMD_BKSP: begin
				if (bs_ok) begin
					ex_res.cursor_pos = CUR_W'(blin);
				end
			end
			CMD_CLEAR: begin
				ex_res.cursor_pos = '0;
				ex_direct         = 1'b0;
			end
			CMD_READ: begin
				ex_res.status = bad;
				ex_direct     = bad;
			end
			default: begin
				ex_direct = 1'b1;
			end
		endcase

		resp_res = res_q;
		if (rd_cell_q) begin
			resp_res.read_char = mem_rd_data[7:0];
			resp_res.read_attr = mem_rd_data[15:8];
		end
	end

	// Memory requests by state. The row move reads COLS cells ahead of the write.
	always_comb begin
		mem_req = '0;
		unique case (state_q)
			ST_INIT, ST_FILL: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = MEM_AW'(scan_q);
				mem_req.wdata = fill_cell_q;
			end
			ST_EXEC: begin
				if (item_q.cmd == CMD_PUT && !bad && !is_nl) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = MEM_AW'(tlin);
					mem_req.wdata = {put_attr, item_q.char_code};
				end else if (item_q.cmd == CMD_BKSP && bs_ok) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = MEM_AW'(blin);
					mem_req.wdata = {default_attr, CH_SPACE};
				end else if (item_q.cmd == CMD_READ && !bad) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = MEM_AW'(tlin);
				end
			end
			ST_MOVE: begin
				mem_req.re    = (scan_q != ADDR_W'(CELLS - COLS));
				mem_req.raddr = MEM_AW'(scan_q + ADDR_W'(COLS));
				mem_req.we    = (scan_q != '0);
				mem_req.waddr = MEM_AW'(scan_q - ADDR_W'(1));
				mem_req.wdata = mem_rd_data;
			end
			ST_IDLE, ST_RESP: begin
				mem_req = '0;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			item_q      <= '0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			cur_lin_q   <= '0;
			scan_q      <= '0;
			fill_cell_q <= '0;
			rd_cell_q   <= 1'b0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					if (scan_q == ADDR_W'(CELLS - 1)) begin
						scan_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						scan_q <= scan_q + ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						item_q  <= cmd_data;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					res_q <= ex_res;
					unique case (item_q.cmd)
						CMD_PUT: begin
							if (!bad) begin
								cur_row_q <= nrow;
								cur_col_q <= ncol;
								cur_lin_q <= nlin;
							end
						end
						CMD_BKSP: begin
							if (bs_ok) begin
								cur_row_q <= brow;
								cur_col_q <= bcol;
								cur_lin_q <= blin;
							end
						end
						CMD_CLEAR: begin
							cur_row_q   <= '0;
							cur_col_q   <= '0;
							cur_lin_q   <= '0;
							fill_cell_q <= {default_attr, CH_SPACE};
						end
						CMD_READ: begin
							rd_cell_q <= !bad;
						end
						default: begin
							rd_cell_q <= 1'b0;
						end
					endcase
					scan_q <= '0;
					if (item_q.cmd == CMD_CLEAR) begin
						state_q <= ST_FILL;
					end else if (item_q.cmd == CMD_PUT && !bad && scroll) begin
						state_q <= ST_MOVE;
					end else if (ex_direct && slot_free) begin
						out_q   <= ex_res;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_MOVE: begin
					if (scan_q == ADDR_W'(CELLS - COLS)) begin
						fill_cell_q <= '0;
						state_q     <= ST_FILL;
					end else begin
						scan_q <= scan_q + ADDR_W'(1);
					end
				end
				ST_FILL: begin
					if (scan_q == ADDR_W'(CELLS - 1)) begin
						scan_q  <= '0;
						state_q <= ST_RESP;
					end else begin
						scan_q <= scan_q + ADDR_W'(1);
					end
				end
				ST_RESP: begin
					if (slot_free) begin
						out_q     <= resp_res;
						rd_cell_q <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/text_console_writer.sv
// Top level of the character-cell text console: configuration register and the
// sequencer and cell store. Depends on tcw_pkg, tcw_ctrl and tcw_cell_mem.
//
//   Channel   Direction  Handshake                Payload
//   cmd       in         cmd_valid / cmd_ready    cmd_data  (tcw_in_t)
//   rsp       out        rsp_valid / rsp_ready    rsp_data  (tcw_out_t)
//   cfg       in         cfg_we (always taken)    cfg_wdata (default attribute)
//
// Put-char and newline without a scroll, backspace and a position error are answered
// from the execute state, over the single write port, if the result register is free.
// A read also passes through the response state, as the cell store's read port is registered.
// A scroll walks the store through one read and one write port. Clear writes one cell
// per cycle. After reset the store is zeroed one cell per cycle, and cmd_ready stays
// low until that pass ends. While the rsp channel stalls, one more command transaction
// is taken and executed; it then waits for the result register, and cmd_ready stays
// low until the held result has gone.
module text_console_writer #(
	parameter int COLS = tcw_pkg::DEF_COLS,
	parameter int ROWS = tcw_pkg::DEF_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  tcw_pkg::tcw_in_t  cmd_data,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output tcw_pkg::tcw_out_t rsp_data,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata
);
	import tcw_pkg::*;

	localparam int CELLS = ROWS * COLS;

	// Default attribute: used for a zero input attribute, for clear and for backspace.
	// The user is to write it only while idle; the block itself does not enforce this.
	logic [7:0]        default_attr_q;
	mem_req_t          mem_req;
	logic [CELL_W-1:0] mem_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_attr_q <= DEF_ATTR_RST;
		end else if (cfg_we) begin
			default_attr_q <= cfg_wdata;
		end
	end

	// The sequencer owns the cursor and drives every access to the store.
	tcw_ctrl #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd_data     (cmd_data),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp_data     (rsp_data),
		.default_attr (default_attr_q),
		.mem_req      (mem_req),
		.mem_rd_data  (mem_rd_data)
	);

	// One cell (attribute high byte, character low byte) per screen position.
	tcw_cell_mem #(
		.DEPTH (CELLS)
	) u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (mem_rd_data)
	);

endmodule

FILE: rtl/tcw_checker.sv
// Port-level checker for the text console, bound to the top level.
// Depends on tcw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcw_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input tcw_pkg::tcw_out_t rsp_data
);
	import tcw_pkg::*;

	// A stalled result stays put.
	`TCW_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

	// One command at a time: an accepted transaction closes the command channel.
	`TCW_ASSERT_NXT(a_one_in_flight, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready)

	// A rejected position yields no cell data and no scroll.
	`TCW_ASSERT_IMP(a_err_clean, clk, arst_n, rsp_valid && rsp_data.status, rsp_data.read_char == 8'd0 && rsp_data.read_attr == 8'd0 && !rsp_data.scrolled)

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
